// ----- design/average_true_range_defines.svh -----
// ---------------------------------------------------------------------------
// Average true range: assertion macros
// Shared property shorthands for the average true range block.
// ---------------------------------------------------------------------------
`ifndef AVERAGE_TRUE_RANGE_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_DEFINES_SVH

// same-cycle implication, held off during reset
`define ATR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define ATR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/atr_pkg.sv -----
// ---------------------------------------------------------------------------
// Average true range: shared package
// Widths, item kinds and the queue entry passed from front to back.
// ---------------------------------------------------------------------------
package atr_pkg;

   localparam int PRICE_W    = 32;
   localparam int PERIOD_W   = 9;
   localparam int PERIOD_MAX = 256;
   localparam int SUM_W      = 40;
   localparam int PROD_W     = PRICE_W + PERIOD_W;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

   // what the back end has to do with a bar
   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,   // no previous close yet
      KIND_ACCUM  = 2'd1,   // add range to the seed sum
      KIND_SEED   = 2'd2,   // add and divide: first average
      KIND_SMOOTH = 2'd3    // Wilder update
   } atr_kind_type;

   typedef struct packed {
      logic [PRICE_W-1:0]  true_range;
      atr_kind_type        kind;
      logic [PERIOD_W-1:0] period;
   } atr_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } atr_queue_status_type;

   // clamp the configured period into 1..PERIOD_MAX
   function automatic logic [PERIOD_W-1:0] effective_period(input logic [PERIOD_W-1:0] p);
      logic [PERIOD_W-1:0] r;
      r = p;
      if (p == '0) begin
         r = PERIOD_W'(1);
      end else if ({1'b0, p} > (PERIOD_W+1)'(PERIOD_MAX)) begin
         r = PERIOD_W'(PERIOD_MAX);
      end
      return r;
   endfunction

endpackage

// ----- design/atr_front.sv -----
// ---------------------------------------------------------------------------
// Average true range: front end
// Takes bars, tracks previous close and bar count, forms the true range and
// classifies each bar before handing it to the queue.
// ---------------------------------------------------------------------------
module atr_front import atr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PERIOD_W-1:0]  period_eff,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [3*PRICE_W-1:0] req_tdata,   // high_price, low_price, close_price
   output logic                 push_valid,
   output atr_entry_type        push_entry,
   input  atr_queue_status_type q_status
);

   logic                stage_valid_ff, stage_valid_in;
   logic [PRICE_W-1:0]  high_ff, low_ff, prev_ff;
   atr_kind_type        kind_ff, kind_in;
   logic [PERIOD_W-1:0] period_ff;
   logic [PRICE_W-1:0]  previous_close_ff, previous_close_in;
   logic [PERIOD_W-1:0] bar_count_ff, bar_count_in;

   logic                accept, push_fire;
   logic [PERIOD_W:0]   count_inc, count_lim;
   logic [PRICE_W-1:0]  in_high, in_low, in_close;
   logic [PRICE_W-1:0]  c1, c2, c3, tr_max;

   assign in_high  = req_tdata[PRICE_W-1:0];
   assign in_low   = req_tdata[2*PRICE_W-1:PRICE_W];
   assign in_close = req_tdata[3*PRICE_W-1:2*PRICE_W];

   // one-deep stage, refilled in the cycle it drains
   assign push_valid = stage_valid_ff;
   assign push_fire  = stage_valid_ff && !q_status.full;
   assign req_tready = !stage_valid_ff || push_fire;
   assign accept     = req_tvalid && req_tready;

   // classify against the bar count as it stands before this bar
   always_comb begin
      priority if (bar_count_ff == '0) begin
         kind_in = KIND_FIRST;
      end else if (bar_count_ff < period_eff) begin
         kind_in = KIND_ACCUM;
      end else if (bar_count_ff == period_eff) begin
         kind_in = KIND_SEED;
      end else begin
         kind_in = KIND_SMOOTH;
      end
   end

   // bar count saturates at period plus one
   always_comb begin
      count_inc = {1'b0, bar_count_ff} + (PERIOD_W+1)'(1);
      count_lim = {1'b0, period_eff} + (PERIOD_W+1)'(1);
      bar_count_in = bar_count_ff;
      previous_close_in = previous_close_ff;
      if (accept) begin
         bar_count_in = (count_inc > count_lim) ? count_lim[PERIOD_W-1:0]
                                                : count_inc[PERIOD_W-1:0];
         previous_close_in = in_close;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_fire) begin
         stage_valid_in = 1'b0;
      end
   end

   // true range: a negative high minus low counts as zero
   always_comb begin
      c1 = (high_ff >= low_ff) ? (high_ff - low_ff) : '0;
      c2 = (high_ff >= prev_ff) ? (high_ff - prev_ff) : (prev_ff - high_ff);
      c3 = (low_ff >= prev_ff) ? (low_ff - prev_ff) : (prev_ff - low_ff);
      tr_max = c1;
      if (c2 > tr_max) begin
         tr_max = c2;
      end
      if (c3 > tr_max) begin
         tr_max = c3;
      end
   end

   always_comb begin
      push_entry.true_range = (kind_ff == KIND_FIRST) ? '0 : tr_max;
      push_entry.kind       = kind_ff;
      push_entry.period     = period_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff    <= 1'b0;
         bar_count_ff      <= '0;
         previous_close_ff <= '0;
      end else begin
         stage_valid_ff    <= stage_valid_in;
         bar_count_ff      <= bar_count_in;
         previous_close_ff <= previous_close_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         high_ff   <= in_high;
         low_ff    <= in_low;
         prev_ff   <= previous_close_ff;
         kind_ff   <= kind_in;
         period_ff <= period_eff;
      end
   end

endmodule

// ----- design/atr_queue.sv -----
// ---------------------------------------------------------------------------
// Average true range: decoupling queue
// Short FIFO of classified bars between front and back ends.
// ---------------------------------------------------------------------------
module atr_queue import atr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  atr_entry_type        push_entry,
   input  logic                 pop,
   output atr_entry_type        pop_entry,
   output atr_queue_status_type q_status
);

   atr_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   assign pop_entry = entry_ff[rd_ptr_ff];

   // pointer wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/atr_back.sv -----
// ---------------------------------------------------------------------------
// Average true range: back end
// Keeps the seed sum and running average, multiplies, divides serially by
// the period and fills the result register.
// ---------------------------------------------------------------------------
module atr_back import atr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  atr_entry_type        pop_entry,
   input  atr_queue_status_type q_status,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*PRICE_W-1:0] rsp_tdata,   // true_range, average_range
   output logic [1:0]           rsp_tuser    // range_valid, average_valid
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } atr_back_state_type;

   atr_back_state_type  state_ff, state_in;
   atr_entry_type       ent_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PRICE_W-1:0]  avg_ff, avg_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0]  rsp_tr_ff, rsp_avg_ff, res_avg;
   logic                rsp_rv_ff, rsp_av_ff, res_av;
   logic                out_load;

   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat, acc;
   logic [PERIOD_W:0]   rem_shift;
   logic                fits;

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_avg_ff, rsp_tr_ff};
   assign rsp_tuser  = {rsp_av_ff, rsp_rv_ff};

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // saturating seed sum and Wilder dividend
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(ent_ff.true_range);
      sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      acc      = prod_ff[SUM_W-1:0] + SUM_W'(ent_ff.true_range);
   end

   // one quotient bit per step, restoring
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      fits      = (rem_shift >= {1'b0, ent_ff.period});
   end

   // result fields; a seeded mean saturates at full scale
   always_comb begin
      res_av  = (ent_ff.kind == KIND_SEED) || (ent_ff.kind == KIND_SMOOTH);
      res_avg = '0;
      if (ent_ff.kind == KIND_SEED) begin
         res_avg = (quo_ff[SUM_W-1:PRICE_W] != '0) ? '1 : quo_ff[PRICE_W-1:0];
      end else if (ent_ff.kind == KIND_SMOOTH) begin
         res_avg = quo_ff[PRICE_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rem_in  = '0;
            step_in = STEP_W'(DIV_STEPS - 1);
            unique case (ent_ff.kind)
               KIND_FIRST: begin
                  state_in = ST_DONE;
               end
               KIND_ACCUM: begin
                  sum_in   = sum_sat;
                  state_in = ST_DONE;
               end
               KIND_SEED: begin
                  sum_in   = sum_sat;
                  quo_in   = sum_sat;
                  state_in = ST_DIV;
               end
               KIND_SMOOTH: begin
                  quo_in   = acc;
                  state_in = ST_DIV;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DIV: begin
            rem_in  = fits ? PERIOD_W'(rem_shift - {1'b0, ent_ff.period})
                           : rem_shift[PERIOD_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (res_av) begin
                  avg_in = res_avg;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         ent_ff <= pop_entry;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= avg_ff * (ent_ff.period - PERIOD_W'(1));
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (out_load) begin
         rsp_tr_ff  <= ent_ff.true_range;
         rsp_rv_ff  <= (ent_ff.kind != KIND_FIRST);
         rsp_avg_ff <= res_avg;
         rsp_av_ff  <= res_av;
      end
   end

endmodule

// ----- design/average_true_range.sv -----
// The back end handles one bar at a time; the front stage and the queue can
// take further bars while its 40-step serial divider runs.
// Reset: synchronous, active high; clears bar count, previous close, sum,
// average, queue and result valid; period returns to 14.
// ---------------------------------------------------------------------------
// Average true range: top level
// Wilder average true range over a stream of Q16.16 price bars.
// ---------------------------------------------------------------------------
`include "average_true_range_defines.svh"

module average_true_range import atr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [PERIOD_W-1:0]  csr_data,    // period
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [3*PRICE_W-1:0] req_tdata,   // high_price, low_price, close_price
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*PRICE_W-1:0] rsp_tdata,   // true_range, average_range
   output logic [1:0]           rsp_tuser    // range_valid, average_valid
);

   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [PERIOD_W-1:0]  period_eff;
   logic                 push_valid, q_pop;
   atr_entry_type        push_entry, pop_entry;
   atr_queue_status_type q_status;

   // period register, always writable
   assign csr_ready  = 1'b1;
   assign period_in  = (csr_valid && csr_ready) ? csr_data : period_ff;
   assign period_eff = effective_period(period_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   atr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .period_eff (period_eff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   atr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   atr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // back end takes one item at a time
   `ATR_ASSERT_NEXT(a_single_pop, clock, reset, q_pop, !q_pop, "back end popped twice in a row")

   // a new bar enters a full stage only when the stage drains into the queue
   `ATR_ASSERT_IMPLIES(a_stage_drain, clock, reset,
                       req_tvalid && req_tready && push_valid, !q_status.full,
                       "bar accepted over a stalled stage")

   // first bar carries no range and no average
   `ATR_ASSERT_IMPLIES(a_first_bar, clock, reset,
                       rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1],
                       "first bar result not clear")

endmodule
